[sv/atnd_pkg.sv]
// Shared constants and types for the adaptive threshold note detector.
// No dependencies; imported by the lane, merge, top and checker modules.

package atnd_pkg;

  // Channel count and field widths fixed by the port list
  localparam int CHANNELS   = 5;
  localparam int CH_W       = 3;
  localparam int PERIOD_W   = 16;
  localparam int PCT_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Register reset values
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd64;
  localparam logic [PCT_W-1:0]    PCT_RESET    = 7'd75;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERCENT = 2'd1;

  // Event queue sizing
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef logic [CHANNELS-1:0] ch_mask_t;

  // Per-word control broadcast to every lane
  typedef struct packed {
    logic load;    // word accepted this cycle
    logic recomp;  // this word recomputes thresholds
    logic cmp;     // compare stage holds a valid word
  } lane_ctl_t;

endpackage

[sv/atnd_lane.sv]
// One sensor channel: min/max tracking, pipelined threshold computation and
// the on/off compare. Depends on atnd_pkg.

module atnd_lane import atnd_pkg::*; #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                   clk,
  input  logic                   rst,
  input  lane_ctl_t              ctl,
  input  logic [PCT_W-1:0]       pct,
  input  logic [SAMPLE_BITS-1:0] sample,
  output logic                   note_on,
  output logic                   change
);

  localparam int SB     = SAMPLE_BITS;
  localparam int PROD_W = SB + PCT_W;      // |span| * pct < 2^(SB+7)
  localparam int K      = PROD_W + 7;      // reciprocal shift, exact for PROD_W-bit inputs
  localparam int R_W    = K - 6;
  localparam int Q_W    = SB + 1;
  localparam int T_W    = SB + 3;
  localparam logic [63:0]    RECIP_L   = ((64'd1 << K) + 64'd99) / 64'd100;
  localparam logic [R_W-1:0] RECIP     = RECIP_L[R_W-1:0];
  localparam logic [SB:0]    MIN_RESET = {1'b1, {SB{1'b0}}};
  localparam logic [SB:0]    THR_MAX   = '1;

  // Channel state
  logic [SB:0]   min_level;
  logic [SB-1:0] max_level;
  logic [SB:0]   threshold;
  logic          note_active;

  // Pipeline registers
  logic [SB-1:0] s1_sample, s2_sample, s3_sample;
  logic [SB:0]   s1_lo, s2_lo, s3_lo;
  logic          s1_neg, s2_neg, s3_neg;
  logic          s1_recomp, s2_recomp, s3_recomp;
  logic [SB:0]   s1_mag;
  logic [PROD_W-1:0] s2_prod;
  logic [Q_W-1:0]    s3_q;

  // Load-stage combinational values
  logic [SB+1:0] diff, diff_neg;
  logic [SB:0]   base_min, min_next, samp_ext;
  logic [SB-1:0] base_max, max_next;
  logic [PROD_W:0]       prod_full;
  logic [PROD_W+R_W-1:0] q_full;
  logic [T_W-1:0]        t_sum;
  logic [SB:0]           thr_sat, thr_new;

  // Span of the current window and the min/max update
  always_comb begin
    diff     = {2'b00, max_level} - {1'b0, min_level};
    diff_neg = -diff;
    samp_ext = {1'b0, sample};
    base_min = ctl.recomp ? MIN_RESET : min_level;
    base_max = ctl.recomp ? '0 : max_level;
    min_next = (samp_ext < base_min) ? samp_ext : base_min;
    max_next = (sample > base_max) ? sample : base_max;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_level <= MIN_RESET;
      max_level <= '0;
    end else if (ctl.load) begin
      min_level <= min_next;
      max_level <= max_next;
    end
  end

  // Stage 1: capture word and signed span as sign + magnitude
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      s1_sample <= sample;
      s1_lo     <= min_level;
      s1_neg    <= diff[SB+1];
      s1_mag    <= diff[SB+1] ? diff_neg[SB:0] : diff[SB:0];
      s1_recomp <= ctl.recomp;
    end
  end

  // Stage 2: |span| * pct
  assign prod_full = s1_mag * pct;

  always_ff @(posedge clk) begin
    s2_sample <= s1_sample;
    s2_lo     <= s1_lo;
    s2_neg    <= s1_neg;
    s2_recomp <= s1_recomp;
    s2_prod   <= prod_full[PROD_W-1:0];
  end

  // Stage 3: divide by 100 through the reciprocal
  assign q_full = s2_prod * RECIP;

  always_ff @(posedge clk) begin
    s3_sample <= s2_sample;
    s3_lo     <= s2_lo;
    s3_neg    <= s2_neg;
    s3_recomp <= s2_recomp;
    s3_q      <= q_full[K +: Q_W];
  end

  // Compare stage: apply sign, saturate, compare with the reading
  always_comb begin
    t_sum = s3_neg ? ({2'b00, s3_lo} - {2'b00, s3_q}) : ({2'b00, s3_lo} + {2'b00, s3_q});
    if (t_sum[T_W-1]) begin
      thr_sat = '0;
    end else if (t_sum[T_W-2]) begin
      thr_sat = THR_MAX;
    end else begin
      thr_sat = t_sum[SB:0];
    end
    thr_new = s3_recomp ? thr_sat : threshold;
    note_on = {1'b0, s3_sample} < thr_new;
    change  = note_on != note_active;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold   <= '0;
      note_active <= 1'b0;
    end else if (ctl.cmp) begin
      threshold   <= thr_new;
      note_active <= note_on;
    end
  end

endmodule

[sv/atnd_merge.sv]
// Event queue and serializer: stores each word's change mask and on flags
// and emits one event per changed channel in ascending order. Depends on atnd_pkg.

module atnd_merge import atnd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  ch_mask_t         wr_mask,
  input  ch_mask_t         wr_on,
  output logic [CNT_W-1:0] count,
  output logic             event_valid,
  input  logic             event_ready,
  output logic [CH_W-1:0]  channel,
  output logic             note_on,
  output logic             last
);

  ch_mask_t           mask_mem [FIFO_DEPTH];
  ch_mask_t           on_mem   [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr, rd_ptr;
  ch_mask_t           done;
  ch_mask_t           left, sel;
  logic               found;
  logic               take, pop;

  // Lowest pending channel of the head word
  always_comb begin
    left    = mask_mem[rd_ptr] & ~done;
    sel     = '0;
    found   = 1'b0;
    channel = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      if (left[c] && !found) begin
        sel[c]  = 1'b1;
        found   = 1'b1;
        channel = CH_W'(c);
      end
    end
    note_on = |(sel & on_mem[rd_ptr]);
    last    = (left & ~sel) == '0;
  end

  assign event_valid = count != '0;
  assign take        = event_valid && event_ready;
  assign pop         = take && last;

  // Queue storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mask_mem[wr_ptr] <= wr_mask;
      on_mem[wr_ptr]   <= wr_on;
    end
  end

  // Pointers, fill count and emitted-channel mask
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      done   <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({wr_en, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
      if (take) begin
        done <= last ? '0 : (done | sel);
      end
    end
  end

endmodule

[sv/adaptive_threshold_note_detector.sv]
// Top level of the adaptive threshold note detector: config registers,
// reload counter, lane array and event queue. Depends on atnd_pkg, atnd_lane, atnd_merge.
//
//   port group   direction  handshake                    payload
//   sample       in         sample_valid / sample_ready  sample_0 .. sample_4
//   event        out        event_valid / event_ready    channel, note_on, last
//   cfg          in         cfg_valid / cfg_ready        cfg_index, cfg_data
//
// A word is accepted every cycle while the event queue has room; its first event
// reaches the port after the span, multiply and reciprocal stages, once the compare
// writes the queue. Events leave one per cycle while event_ready is high; the single
// event port limits sustained throughput, and an 8-word queue absorbs bursts.
// Synchronous reset clears state; ready stays low while reset is high.

module adaptive_threshold_note_detector import atnd_pkg::*; #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   sample_valid,
  output logic                   sample_ready,
  input  logic [SAMPLE_BITS-1:0] sample_0,
  input  logic [SAMPLE_BITS-1:0] sample_1,
  input  logic [SAMPLE_BITS-1:0] sample_2,
  input  logic [SAMPLE_BITS-1:0] sample_3,
  input  logic [SAMPLE_BITS-1:0] sample_4,
  output logic                   event_valid,
  input  logic                   event_ready,
  output logic [CH_W-1:0]        channel,
  output logic                   note_on,
  output logic                   last,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [PERIOD_W-1:0] period;
  logic [PCT_W-1:0]    pct;
  logic [PERIOD_W-1:0] readings_left;
  logic                recomp, accept;
  logic                v1, v2, v3;
  logic [1:0]          inflight;
  logic [CNT_W-1:0]    fifo_count, occupancy;
  lane_ctl_t           ctl;
  ch_mask_t            lane_on, lane_change;
  logic [SAMPLE_BITS-1:0] samples [CHANNELS];

  assign samples[0] = sample_0;
  assign samples[1] = sample_1;
  assign samples[2] = sample_2;
  assign samples[3] = sample_3;
  assign samples[4] = sample_4;

  // Configuration registers
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      period <= PERIOD_RESET;
      pct    <= PCT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PERIOD:  period <= cfg_data;
        REG_PERCENT: pct    <= cfg_data[PCT_W-1:0];
        default:     ;
      endcase
    end
  end

  // Credit check: queue entries plus words still in the lanes
  assign inflight     = {1'b0, v1} + {1'b0, v2} + {1'b0, v3};
  assign occupancy    = fifo_count + CNT_W'(inflight);
  assign sample_ready = !rst && (occupancy < CNT_W'(FIFO_DEPTH));
  assign accept       = sample_valid && sample_ready;

  // Reload counter
  assign recomp = readings_left <= PERIOD_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      readings_left <= '0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (accept) begin
        readings_left <= recomp ? period : readings_left - 1'b1;
      end
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
    end
  end

  assign ctl = '{load: accept, recomp: recomp, cmp: v3};

  // One lane per channel
  for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
    atnd_lane #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_lane (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .pct     (pct),
      .sample  (samples[g]),
      .note_on (lane_on[g]),
      .change  (lane_change[g])
    );
  end

  // Merge lane results into the event stream
  atnd_merge u_merge (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (v3 && (|lane_change)),
    .wr_mask     (lane_change),
    .wr_on       (lane_on),
    .count       (fifo_count),
    .event_valid (event_valid),
    .event_ready (event_ready),
    .channel     (channel),
    .note_on     (note_on),
    .last        (last)
  );

endmodule

[sv/atnd_checker.sv]
// Port-level checks for the adaptive threshold note detector, bound to the
// top level. Depends on atnd_pkg and adaptive_threshold_note_detector.

module atnd_checker import atnd_pkg::*; (
  input logic            clk,
  input logic            rst,
  input logic            sample_valid,
  input logic            sample_ready,
  input logic            event_valid,
  input logic            event_ready,
  input logic [CH_W-1:0] channel,
  input logic            note_on,
  input logic            last
);

  // Events only name existing channels
  a_channel_range: assert property (@(posedge clk) disable iff (rst)
    event_valid |-> (channel < CH_W'(CHANNELS)))
    else $error("event channel out of range");

  // A stalled event holds its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    event_valid && !event_ready |=> event_valid && $stable(channel) && $stable(note_on)
      && $stable(last))
    else $error("stalled event changed");

  // Events of one word follow back to back in ascending channel order
  a_ascending: assert property (@(posedge clk) disable iff (rst)
    event_valid && event_ready && !last |=> event_valid && (channel > $past(channel)))
    else $error("events of one word out of order");

  // An event stream starting from empty traces back to an accepted word
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(event_valid) |-> $past(sample_valid && sample_ready, 4))
    else $error("event without a matching accepted word");

endmodule

bind adaptive_threshold_note_detector atnd_checker u_atnd_checker (.*);

[tb/note_event_checker.sv]
// Event checker for the adaptive threshold note detector: mirrors the detector
// state from accepted sample words and register writes, and checks every event.
// Depends on atnd_pkg.

module note_event_checker import atnd_pkg::*; #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   sample_valid,
  input  logic                   sample_ready,
  input  logic [SAMPLE_BITS-1:0] sample_0,
  input  logic [SAMPLE_BITS-1:0] sample_1,
  input  logic [SAMPLE_BITS-1:0] sample_2,
  input  logic [SAMPLE_BITS-1:0] sample_3,
  input  logic [SAMPLE_BITS-1:0] sample_4,
  input  logic                   event_valid,
  input  logic                   event_ready,
  input  logic [CH_W-1:0]        channel,
  input  logic                   note_on,
  input  logic                   last,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     fail_count,
  output int                     pending_events
);

  localparam int PCT_SCALE    = 100;
  localparam int THRESH_CEIL  = (2 << SAMPLE_BITS) - 1;
  localparam int REPORT_LIMIT = 10;

  typedef logic [SAMPLE_BITS-1:0] reading_t;
  typedef logic [SAMPLE_BITS:0]   level_t;
  typedef logic [CHANNELS-1:0][SAMPLE_BITS-1:0] sample_word_t;

  localparam level_t MIN_LEVEL_RESET = level_t'(1 << SAMPLE_BITS);

  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic            on;
    logic            fin;
  } note_event_t;

  // Events still owed by the detector, oldest first
  note_event_t expected_notes[$];

  // Mirrored detector state
  level_t              min_seen   [CHANNELS];
  reading_t            max_seen   [CHANNELS];
  level_t              on_below   [CHANNELS];
  logic [CHANNELS-1:0] note_held;
  logic [PERIOD_W:0]   readings_left_q;
  logic [PERIOD_W-1:0] period_q;
  logic [PCT_W-1:0]    percent_q;
  int                  errors;

  // lo + (hi - lo) * pct / 100, signed, truncating toward zero, then clamped
  function automatic level_t threshold_between(input level_t lo, input reading_t hi,
                                               input logic [PCT_W-1:0] pct);
    int span;
    int t;
    span = int'(hi) - int'(lo);
    t = int'(lo) + (span * int'(pct)) / PCT_SCALE;
    if (t < 0) t = 0;
    if (t > THRESH_CEIL) t = THRESH_CEIL;
    return level_t'(t);
  endfunction

  // Counter step, then per-channel min/max update and on/off compare
  task automatic predict_notes(input sample_word_t word);
    note_event_t found [CHANNELS];
    int          n;
    logic        on;
    reading_t    s;
    n = 0;
    if (readings_left_q <= 1) begin
      for (int c = 0; c < CHANNELS; c++) begin
        on_below[c] = threshold_between(min_seen[c], max_seen[c], percent_q);
        min_seen[c] = MIN_LEVEL_RESET;
        max_seen[c] = '0;
      end
      readings_left_q = {1'b0, period_q};
    end else begin
      readings_left_q = readings_left_q - 1'b1;
    end
    for (int c = 0; c < CHANNELS; c++) begin
      s = word[c];
      if ({1'b0, s} < min_seen[c]) min_seen[c] = {1'b0, s};
      if (s > max_seen[c]) max_seen[c] = s;
      on = ({1'b0, s} < on_below[c]);
      if (on != note_held[c]) begin
        note_held[c] = on;
        found[n] = '{ch: CH_W'(c), on: on, fin: 1'b0};
        n++;
      end
    end
    for (int k = 0; k < n; k++) begin
      if (k == n - 1) found[k].fin = 1'b1;
      expected_notes.push_back(found[k]);
    end
  endtask

  task automatic note_failure(input string what, input note_event_t want,
                              input note_event_t got);
    if (errors < REPORT_LIMIT)
      $display("%s: expected ch %0d on %0b last %0b, got ch %0d on %0b last %0b",
               what, want.ch, want.on, want.fin, got.ch, got.on, got.fin);
    errors++;
  endtask

  // Events are checked before the same edge's word is predicted: an event
  // never belongs to a word accepted in the same cycle
  always @(posedge clk) begin
    note_event_t got;
    note_event_t want;
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        min_seen[c] = MIN_LEVEL_RESET;
        max_seen[c] = '0;
        on_below[c] = '0;
      end
      note_held       = '0;
      readings_left_q = '0;
      period_q        = PERIOD_RESET;
      percent_q       = PCT_RESET;
      errors          = 0;
      expected_notes.delete();
    end else begin
      if (event_valid && event_ready) begin
        got = '{ch: channel, on: note_on, fin: last};
        if (expected_notes.size() == 0) begin
          note_failure("event with none pending", '0, got);
        end else begin
          want = expected_notes.pop_front();
          if (got !== want) note_failure("event mismatch", want, got);
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_PERIOD) period_q = cfg_data[PERIOD_W-1:0];
        else if (cfg_index == REG_PERCENT) percent_q = cfg_data[PCT_W-1:0];
      end
      if (sample_valid && sample_ready)
        predict_notes({sample_4, sample_3, sample_2, sample_1, sample_0});
    end
    fail_count     = errors;
    pending_events = expected_notes.size();
  end

endmodule

[tb/testbench.sv]
// Top of the note detector testbench: clock, reset, sample and register
// stimulus, event backpressure, watchdog and verdict.
// Depends on atnd_pkg, adaptive_threshold_note_detector and note_event_checker.

module testbench;
  import atnd_pkg::*;

  localparam int SAMPLE_BITS     = 10;
  localparam int SAMPLE_TOP      = (1 << SAMPLE_BITS) - 1;
  localparam int STUCK_LIMIT     = 2000;
  localparam int SETTLE_CYCLES   = 12;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int OPENING_WORDS   = 65;
  localparam int PHASES          = 8;
  localparam int PHASE_WORDS     = 43;

  // Unused register slots; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef logic [CHANNELS-1:0][SAMPLE_BITS-1:0] sample_word_t;
  typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   sample_valid;
  logic                   sample_ready;
  logic [SAMPLE_BITS-1:0] sample_0, sample_1, sample_2, sample_3, sample_4;
  logic                   event_valid;
  logic                   event_ready = 1'b0;
  logic [CH_W-1:0]        channel;
  logic                   note_on;
  logic                   last;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int                     fail_count;
  int                     pending_events;

  // Receiver state
  logic                rx_hold_req;
  logic                hold_done  = 1'b0;
  int                  hold_left  = 0;
  int                  mode_left  = 0;
  logic [1:0]          rx_phase   = 2'd0;
  rx_mode_t            rx_mode    = RX_ALWAYS;

  // Per-channel light level used to shape sensor-like words
  logic [CHANNELS-1:0] lit = '0;
  int                  stuck_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  adaptive_threshold_note_detector #(.SAMPLE_BITS(SAMPLE_BITS)) u_top (
    .clk, .rst,
    .sample_valid, .sample_ready,
    .sample_0, .sample_1, .sample_2, .sample_3, .sample_4,
    .event_valid, .event_ready, .channel, .note_on, .last,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  note_event_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_checker (
    .clk, .rst,
    .sample_valid, .sample_ready,
    .sample_0, .sample_1, .sample_2, .sample_3, .sample_4,
    .event_valid, .event_ready, .channel, .note_on, .last,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count, .pending_events
  );

  // Event receiver: one long hold-off on request, else a changing stall pattern
  always @(posedge clk) begin
    if (hold_left != 0) begin
      event_ready <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (rx_hold_req && !hold_done) begin
      event_ready <= 1'b0;
      hold_left   <= HOLD_OFF_CYCLES;
      hold_done   <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        rx_mode   <= rx_mode_t'($urandom_range(0, 3));
        mode_left <= $urandom_range(16, 96);
      end else begin
        mode_left <= mode_left - 1;
      end
      rx_phase <= rx_phase + 2'd1;
      case (rx_mode)
        RX_ALWAYS: event_ready <= 1'b1;
        RX_COIN:   event_ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: event_ready <= (rx_phase == 2'd0);
        default:   event_ready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // Watchdog: too long without any handshake ends the run
  always @(posedge clk) begin
    if (rst || (sample_valid && sample_ready) || (event_valid && event_ready) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  function automatic sample_word_t word5(input int a, input int b, input int c,
                                         input int d, input int e);
    return {SAMPLE_BITS'(e), SAMPLE_BITS'(d), SAMPLE_BITS'(c), SAMPLE_BITS'(b),
            SAMPLE_BITS'(a)};
  endfunction

  // Mostly dark/bright levels with noise and occasional flips; some uniform
  // noise words and some words pinned to the range ends
  task automatic make_word(output sample_word_t w);
    int kind;
    int v;
    kind = $urandom_range(0, 99);
    for (int c = 0; c < CHANNELS; c++) begin
      if (kind < 15) begin
        w[c] = SAMPLE_BITS'($urandom);
      end else if (kind < 20) begin
        w[c] = $urandom_range(0, 1) ? SAMPLE_BITS'(SAMPLE_TOP) : '0;
      end else begin
        if ($urandom_range(0, 5) == 0) lit[c] = ~lit[c];
        v = (lit[c] ? 850 : 150) + $urandom_range(0, 200) - 100;
        w[c] = SAMPLE_BITS'(v);
      end
    end
  endtask

  // Valid stays high after the handshake; the caller lowers it for a gap
  task automatic send_word(input sample_word_t w);
    sample_valid <= 1'b1;
    sample_0     <= w[0];
    sample_1     <= w[1];
    sample_2     <= w[2];
    sample_3     <= w[3];
    sample_4     <= w[4];
    do @(posedge clk); while (!sample_ready);
  endtask

  // Random words in bursts with random gaps; steady means no gaps at all
  task automatic send_words(input int count, input bit steady);
    sample_word_t w;
    int           burst_left;
    int           gap;
    burst_left = 0;
    for (int i = 0; i < count; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap != 0) begin
          sample_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      make_word(w);
      send_word(w);
      burst_left--;
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Stop sending, wait for every owed event, then let the pipeline empty
  task automatic wait_drained();
    sample_valid <= 1'b0;
    do @(negedge clk); while (pending_events != 0);
    repeat (SETTLE_CYCLES + 1) @(posedge clk);
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] period_data;
    logic [CFG_DATA_W-1:0] pct_data;
    rst          = 1'b1;
    sample_valid = 1'b0;
    sample_0     = '0;
    sample_1     = '0;
    sample_2     = '0;
    sample_3     = '0;
    sample_4     = '0;
    cfg_valid    = 1'b0;
    cfg_index    = REG_PERIOD;
    cfg_data     = '0;
    rx_hold_req  = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset register values; the first word recomputes from the empty range
    send_word(word5(0, 0, 0, 0, 0));
    send_word(word5(1023, 1023, 1023, 1023, 1023));
    send_word(word5(0, 1023, 255, 256, 512));
    send_word(word5(256, 255, 1023, 0, 1));
    send_word(word5('h2AA, 'h155, 'h2AA, 'h155, 'h2AA));
    send_word(word5('h155, 'h2AA, 'h155, 'h2AA, 'h155));
    // repeated word: no channel changes, no events
    send_word(word5('h155, 'h2AA, 'h155, 'h2AA, 'h155));
    send_word(word5(255, 255, 255, 255, 255));
    send_word(word5(256, 256, 256, 256, 256));
    send_word(word5(1, 1, 1, 1, 1));
    send_word(word5(0, 1023, 0, 1023, 0));
    send_word(word5(1023, 0, 1023, 0, 1023));
    // fill out one reset-length period so the countdown expires here
    send_words(OPENING_WORDS - 12, 1'b0);

    // Register settings: period one and zero, percent 0, 100 and above 100,
    // spare slots, a random setting and the longest period last
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      case (p)
        0:       begin period_data = 16'd1;  pct_data = 16'd0;    end
        1:       begin period_data = 16'd0;  pct_data = 16'd100;  end
        2:       begin period_data = 16'd2;  pct_data = 16'hFFFF; end
        3:       begin period_data = 16'd7;  pct_data = 16'd50;   end
        4:       begin period_data = 16'd3;  pct_data = 16'd33;   end
        5:       begin period_data = 16'd16; pct_data = 16'd90;   end
        6: begin
          period_data = 16'($urandom_range(1, 12));
          pct_data    = 16'($urandom);
        end
        default: begin period_data = 16'hFFFF; pct_data = 16'($urandom); end
      endcase
      write_reg(REG_PERIOD, period_data);
      write_reg(REG_PERCENT, pct_data);
      if (p == 2) begin
        write_reg(REG_SPARE_2, 16'($urandom));
        write_reg(REG_SPARE_3, 16'($urandom));
      end
      cfg_valid <= 1'b0;
      // long receiver hold-off while words keep coming, to back up the input
      if (p == 4) rx_hold_req <= 1'b1;
      send_words(PHASE_WORDS, p == 5);
    end

    wait_drained();
    @(negedge clk);
    if (fail_count == 0 && pending_events == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
